FILE: sv/median_filter_rgba8_window_defines.svh
`ifndef MEDIAN_FILTER_RGBA8_WINDOW_DEFINES_SVH
`define MEDIAN_FILTER_RGBA8_WINDOW_DEFINES_SVH
// same-cycle implication check
`define MFW_ASSERT_NOW(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("mfw check failed");
// next-cycle implication check
`define MFW_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("mfw check failed");
`endif

FILE: sv/mfw_pkg.sv
package mfw_pkg;

  localparam int DEF_MAX_RADIUS = 7;
  localparam int DEF_MAX_WIDTH  = 1024;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_RADIUS = 2'd2;

  localparam logic [10:0] RST_WIDTH  = 11'd640;
  localparam logic [15:0] RST_HEIGHT = 16'd480;
  localparam logic [2:0]  RST_RADIUS = 3'd2;

  typedef struct packed {
    logic       start;
    logic       sample;
    logic       resolve;
    logic [2:0] bitsel;
  } lane_ctrl_t;

endpackage

FILE: sv/mfw_ram.sv
module mfw_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: sv/mfw_lane.sv
module mfw_lane #(
  parameter int NW = 8
) (
  input  logic                   clk,
  input  mfw_pkg::lane_ctrl_t    ctrl,
  input  logic [NW-1:0]          rank,
  input  logic [7:0]             sample_byte,
  output logic [7:0]             median
);

  logic [7:0]    prefix;
  logic [NW-1:0] k;
  logic [NW-1:0] count;
  logic [7:0]    mask;
  logic          match;

  assign mask   = 8'hFF << ({1'b0, ctrl.bitsel} + 4'd1);
  assign match  = (((sample_byte ^ prefix) & mask) == 8'd0) && !sample_byte[ctrl.bitsel];
  assign median = prefix;

  // radix select: one bit of the rank-k value per sweep
  always_ff @(posedge clk) begin
    if (ctrl.start) begin
      prefix <= 8'd0;
      k      <= rank;
      count  <= '0;
    end else if (ctrl.sample) begin
      if (match) begin
        count <= count + 1'b1;
      end
    end else if (ctrl.resolve) begin
      if (k >= count) begin
        k                   <= k - count;
        prefix[ctrl.bitsel] <= 1'b1;
      end
      count <= '0;
    end
  end

endmodule

FILE: sv/median_filter_rgba8_window.sv
// channel | signals                          | transfer
// input   | in_valid, in_ready, *_in         | one pixel per transaction
// output  | out_valid, out_ready, out_*, ... | one filtered pixel per transaction
// config  | cfg_we, cfg_index, cfg_data      | write, no wait
// each result takes one line store read per window pixel per bit sweep, three channel
// lanes in parallel
// an input that finishes no window visits only IDLE and SETUP; one that finishes k
// windows also delivers k results
// one pixel in flight; the next is taken once every result of it is delivered
// rst resets state, position, config and sample flag; line store is not cleared
`include "median_filter_rgba8_window_defines.svh"
module median_filter_rgba8_window #(
  parameter int MAX_RADIUS = mfw_pkg::DEF_MAX_RADIUS,
  parameter int MAX_WIDTH  = mfw_pkg::DEF_MAX_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [7:0]  red_in,
  input  logic [7:0]  green_in,
  input  logic [7:0]  blue_in,
  input  logic [7:0]  alpha_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [9:0]  out_col,
  output logic [15:0] out_row,
  output logic [7:0]  red_median,
  output logic [7:0]  green_median,
  output logic [7:0]  blue_median,
  output logic [7:0]  alpha_copy,
  output logic        run_last,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  localparam int SR    = 2 * MAX_RADIUS + 1;
  localparam int SW    = $clog2(SR + 1);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int RW    = $clog2(MAX_RADIUS + 1);
  localparam int NW    = $clog2(SR * SR + 1);
  localparam int DEPTH = SR * MAX_WIDTH;
  localparam int AW    = $clog2(DEPTH);

  localparam logic [2:0] S_IDLE       = 3'd0;
  localparam logic [2:0] S_SETUP      = 3'd1;
  localparam logic [2:0] S_SCAN       = 3'd2;
  localparam logic [2:0] S_DRAIN      = 3'd3;
  localparam logic [2:0] S_RESOLVE    = 3'd4;
  localparam logic [2:0] S_ALPHA_RD   = 3'd5;
  localparam logic [2:0] S_ALPHA_WAIT = 3'd6;
  localparam logic [2:0] S_OUT        = 3'd7;

  logic [2:0]    state;
  logic [10:0]   image_width;
  logic [15:0]   image_height;
  logic [2:0]    window_radius;
  logic [CW-1:0] cx, ox, xlo, xhi;
  logic [15:0]   cy, oy, ylo, yhi;
  logic [SW-1:0] slot, i, j;
  logic [2:0]    bitsel;
  logic          sample_q;
  logic [7:0]    alpha_q;

  logic [CW:0]   w_eff;
  logic [15:0]   h_eff;
  logic [RW-1:0] r_eff;
  logic [SW-1:0] two_r;
  logic [NW-1:0] rank;
  logic          accept, restart, last, ok;
  logic [CW-1:0] acc_cx, adv_cx;
  logic [15:0]   acc_cy, adv_cy;
  logic [SW-1:0] acc_slot, adv_slot;
  logic [CW-1:0] xlo_c, xhi_c, rd_x;
  logic [15:0]   ylo_c, yhi_c, rd_y;
  logic          rows_ok, cols_ok;
  logic [CW:0]   tx, rx;
  logic [16:0]   ty, ry;
  logic [SW-1:0] diff, rd_slot;
  logic [SW:0]   slot_wrap;
  logic [AW-1:0] waddr, raddr;
  logic [31:0]   rdata;
  mfw_pkg::lane_ctrl_t ctrl;

  always_comb begin
    if (image_width == 11'd0) begin
      w_eff = (CW+1)'(1);
    end else if (32'(image_width) > MAX_WIDTH) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(image_width);
    end
    h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
    if (window_radius == 3'd0) begin
      r_eff = RW'(1);
    end else if (32'(window_radius) > MAX_RADIUS) begin
      r_eff = RW'(MAX_RADIUS);
    end else begin
      r_eff = RW'(window_radius);
    end
    two_r = SW'(2 * 32'(r_eff));
    rank  = NW'(2 * 32'(r_eff) * (32'(r_eff) + 1));
  end

  assign in_ready = (state == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign restart  = (32'(cx) >= 32'(w_eff)) || (cy >= h_eff);
  assign acc_cx   = restart ? '0 : cx;
  assign acc_cy   = restart ? 16'd0 : cy;
  assign acc_slot = restart ? '0 : slot;

  // next pixel position after the current one
  always_comb begin
    adv_cx   = cx + 1'b1;
    adv_cy   = cy;
    adv_slot = slot;
    if (32'(cx) + 1 >= 32'(w_eff)) begin
      adv_cx = '0;
      if (32'(cy) + 1 >= 32'(h_eff)) begin
        adv_cy   = 16'd0;
        adv_slot = '0;
      end else begin
        adv_cy   = cy + 16'd1;
        adv_slot = (32'(slot) == SR - 1) ? '0 : slot + 1'b1;
      end
    end
  end

  // range of windows completed by the current pixel
  always_comb begin
    rows_ok = 1'b1;
    cols_ok = 1'b1;
    if (cy == h_eff - 16'd1) begin
      ylo_c = (cy >= 16'(r_eff)) ? cy - 16'(r_eff) : 16'd0;
      yhi_c = cy;
    end else if (cy >= 16'(r_eff)) begin
      ylo_c = cy - 16'(r_eff);
      yhi_c = ylo_c;
    end else begin
      rows_ok = 1'b0;
      ylo_c   = 16'd0;
      yhi_c   = 16'd0;
    end
    if (32'(cx) == 32'(w_eff) - 1) begin
      xlo_c = (32'(cx) >= 32'(r_eff)) ? cx - CW'(r_eff) : '0;
      xhi_c = cx;
    end else if (32'(cx) >= 32'(r_eff)) begin
      xlo_c = cx - CW'(r_eff);
      xhi_c = xlo_c;
    end else begin
      cols_ok = 1'b0;
      xlo_c   = '0;
      xhi_c   = '0;
    end
    ok = rows_ok && cols_ok;
  end

  // clamped window read address
  always_comb begin
    if (state == S_ALPHA_RD) begin
      rd_x = ox;
      rd_y = oy;
      tx   = '0;
      ty   = '0;
      rx   = '0;
      ry   = '0;
    end else begin
      tx = {1'b0, ox} + (CW+1)'(j);
      ty = {1'b0, oy} + 17'(i);
      rx = (tx < (CW+1)'(r_eff)) ? '0 : tx - (CW+1)'(r_eff);
      if (rx > w_eff - 1'b1) begin
        rx = w_eff - 1'b1;
      end
      rd_x = CW'(rx);
      ry = (ty < 17'(r_eff)) ? 17'd0 : ty - 17'(r_eff);
      if (ry > {1'b0, h_eff} - 17'd1) begin
        ry = {1'b0, h_eff} - 17'd1;
      end
      rd_y = ry[15:0];
    end
    diff      = SW'(cy - rd_y);
    slot_wrap = {1'b0, slot} + (SW+1)'(SR) - {1'b0, diff};
    rd_slot   = (slot >= diff) ? slot - diff : SW'(slot_wrap);
    raddr     = AW'(32'(rd_slot) * MAX_WIDTH + 32'(rd_x));
    waddr     = AW'(32'(acc_slot) * MAX_WIDTH + 32'(acc_cx));
  end

  assign last = (oy == yhi) && (ox == xhi);

  assign ctrl.start   = ((state == S_SETUP) && ok) || ((state == S_OUT) && out_ready && !last);
  assign ctrl.sample  = sample_q;
  assign ctrl.resolve = (state == S_RESOLVE);
  assign ctrl.bitsel  = bitsel;

  mfw_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_line_store (
    .clk  (clk),
    .we   (accept),
    .waddr(waddr),
    .wdata({alpha_in, blue_in, green_in, red_in}),
    .raddr(raddr),
    .rdata(rdata)
  );

  mfw_lane #(.NW(NW)) u_lane_red (
    .clk(clk), .ctrl(ctrl), .rank(rank), .sample_byte(rdata[7:0]), .median(red_median)
  );
  mfw_lane #(.NW(NW)) u_lane_green (
    .clk(clk), .ctrl(ctrl), .rank(rank), .sample_byte(rdata[15:8]), .median(green_median)
  );
  mfw_lane #(.NW(NW)) u_lane_blue (
    .clk(clk), .ctrl(ctrl), .rank(rank), .sample_byte(rdata[23:16]), .median(blue_median)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      image_width   <= mfw_pkg::RST_WIDTH;
      image_height  <= mfw_pkg::RST_HEIGHT;
      window_radius <= mfw_pkg::RST_RADIUS;
      cx            <= '0;
      cy            <= 16'd0;
      slot          <= '0;
      sample_q      <= 1'b0;
    end else begin
      sample_q <= (state == S_SCAN);
      if (cfg_we && (cfg_index == mfw_pkg::REG_WIDTH || cfg_index == mfw_pkg::REG_HEIGHT ||
                     cfg_index == mfw_pkg::REG_RADIUS)) begin
        if (cfg_index == mfw_pkg::REG_WIDTH) begin
          image_width <= cfg_data[10:0];
        end else if (cfg_index == mfw_pkg::REG_HEIGHT) begin
          image_height <= cfg_data;
        end else begin
          window_radius <= cfg_data[2:0];
        end
        cx   <= '0;
        cy   <= 16'd0;
        slot <= '0;
      end
      case (state)
        S_IDLE: begin
          if (accept) begin
            cx    <= acc_cx;
            cy    <= acc_cy;
            slot  <= acc_slot;
            state <= S_SETUP;
          end
        end
        S_SETUP: begin
          if (ok) begin
            ox     <= xlo_c;
            oy     <= ylo_c;
            xlo    <= xlo_c;
            xhi    <= xhi_c;
            ylo    <= ylo_c;
            yhi    <= yhi_c;
            bitsel <= 3'd7;
            i      <= '0;
            j      <= '0;
            state  <= S_SCAN;
          end else begin
            cx    <= adv_cx;
            cy    <= adv_cy;
            slot  <= adv_slot;
            state <= S_IDLE;
          end
        end
        S_SCAN: begin
          if (j == two_r) begin
            j <= '0;
            i <= i + 1'b1;
            if (i == two_r) begin
              state <= S_DRAIN;
            end
          end else begin
            j <= j + 1'b1;
          end
        end
        S_DRAIN: begin
          state <= S_RESOLVE;
        end
        S_RESOLVE: begin
          if (bitsel == 3'd0) begin
            state <= S_ALPHA_RD;
          end else begin
            bitsel <= bitsel - 3'd1;
            i      <= '0;
            j      <= '0;
            state  <= S_SCAN;
          end
        end
        S_ALPHA_RD: begin
          state <= S_ALPHA_WAIT;
        end
        S_ALPHA_WAIT: begin
          alpha_q <= rdata[31:24];
          state   <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) begin
            if (last) begin
              cx    <= adv_cx;
              cy    <= adv_cy;
              slot  <= adv_slot;
              state <= S_IDLE;
            end else begin
              if (ox == xhi) begin
                ox <= xlo;
                oy <= oy + 16'd1;
              end else begin
                ox <= ox + 1'b1;
              end
              bitsel <= 3'd7;
              i      <= '0;
              j      <= '0;
              state  <= S_SCAN;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid  = (state == S_OUT);
  assign out_col    = 10'(ox);
  assign out_row    = oy;
  assign alpha_copy = alpha_q;
  assign run_last   = last;

  `MFW_ASSERT_NOW(a_no_in_during_out, clk, rst, accept, !out_valid)
  `MFW_ASSERT_NOW(a_out_row_done, clk, rst, out_valid, (out_row <= cy) && (out_row >= ylo))
  `MFW_ASSERT_NEXT(a_last_to_idle, clk, rst, out_valid && out_ready && run_last, in_ready)

endmodule

FILE: tb/median_filter_rgba8_window_test.sv
module median_filter_rgba8_window_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REG_UNUSED = 2'd3;
  localparam int STORE_ROWS = 2 * mfw_pkg::DEF_MAX_RADIUS + 1;

  typedef struct packed {
    logic [9:0]  col;
    logic [15:0] row;
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [7:0]  alpha;
    logic        last;
  } filtered_px_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  red_in = '0, green_in = '0, blue_in = '0, alpha_in = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [9:0]  out_col;
  logic [15:0] out_row;
  logic [7:0]  red_median, green_median, blue_median, alpha_copy;
  logic        run_last;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  median_filter_rgba8_window dut (.*);

  always #1 clk = ~clk;

  // predictor state
  logic [31:0]  line_mem [STORE_ROWS * mfw_pkg::DEF_MAX_WIDTH];
  logic [10:0]  img_width = mfw_pkg::RST_WIDTH;
  logic [15:0]  img_height = mfw_pkg::RST_HEIGHT;
  logic [2:0]   win_radius = mfw_pkg::RST_RADIUS;
  int unsigned  next_col = 0, next_row = 0;
  filtered_px_t pending_px [$];

  int errors = 0;
  int results_seen = 0;
  int pixels_sent = 0;
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_cycles = 0;

  initial begin
    foreach (line_mem[i]) line_mem[i] = '0;
  end

  task automatic report_mismatch(input string what);
    $display("mismatch at %0t: %s", $time, what);
    errors++;
  endtask

  function automatic logic [7:0] window_median(int xc, int yc, int w, int h, int r,
                                               int shift);
    int hist [256];
    int half, count, bin, x, y;
    foreach (hist[i]) hist[i] = 0;
    half = ((2 * r + 1) * (2 * r + 1)) / 2;
    for (int dy = -r; dy <= r; dy++) begin
      y = yc + dy;
      if (y < 0) y = 0;
      if (y > h - 1) y = h - 1;
      for (int dx = -r; dx <= r; dx++) begin
        x = xc + dx;
        if (x < 0) x = 0;
        if (x > w - 1) x = w - 1;
        hist[(line_mem[(y % STORE_ROWS) * mfw_pkg::DEF_MAX_WIDTH + x] >> shift) & 255]++;
      end
    end
    count = 0;
    for (bin = 0; bin < 255; bin++) begin
      count += hist[bin];
      if (count > half) break;
    end
    return bin[7:0];
  endfunction

  task automatic predict_pixel(input logic [7:0] r8, g8, b8, a8);
    int w, h, r, cx, cy, ylo, yhi, xlo, xhi;
    bit rows_ok, cols_ok;
    filtered_px_t px;
    w = (img_width == 0) ? 1 : (img_width > mfw_pkg::DEF_MAX_WIDTH ?
                                mfw_pkg::DEF_MAX_WIDTH : img_width);
    h = (img_height == 0) ? 1 : img_height;
    r = (win_radius == 0) ? 1 : (win_radius > mfw_pkg::DEF_MAX_RADIUS ?
                                 mfw_pkg::DEF_MAX_RADIUS : win_radius);
    cx = next_col;
    cy = next_row;
    if (cx >= w || cy >= h) begin
      cx = 0;
      cy = 0;
    end
    line_mem[(cy % STORE_ROWS) * mfw_pkg::DEF_MAX_WIDTH + cx] = {a8, b8, g8, r8};
    rows_ok = 1;
    cols_ok = 1;
    if (cy == h - 1) begin
      ylo = cy >= r ? cy - r : 0;
      yhi = cy;
    end else if (cy >= r) begin
      ylo = cy - r;
      yhi = ylo;
    end else rows_ok = 0;
    if (cx == w - 1) begin
      xlo = cx >= r ? cx - r : 0;
      xhi = cx;
    end else if (cx >= r) begin
      xlo = cx - r;
      xhi = xlo;
    end else cols_ok = 0;
    if (rows_ok && cols_ok) begin
      for (int y = ylo; y <= yhi; y++) begin
        for (int x = xlo; x <= xhi; x++) begin
          px.col = x[9:0];
          px.row = y[15:0];
          px.red = window_median(x, y, w, h, r, 0);
          px.green = window_median(x, y, w, h, r, 8);
          px.blue = window_median(x, y, w, h, r, 16);
          px.alpha = line_mem[(y % STORE_ROWS) * mfw_pkg::DEF_MAX_WIDTH + x][31:24];
          px.last = (y == yhi && x == xhi);
          pending_px = {pending_px, px};
        end
      end
    end
    cx++;
    if (cx >= w) begin
      cx = 0;
      cy++;
      if (cy >= h) cy = 0;
    end
    next_col = cx & 32'h3FF;
    next_row = cy & 32'hFFFF;
  endtask

  // receiver
  always @(posedge clk) begin
    if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= stall_pct);
    end
  end

  // result checker
  always @(posedge clk) begin
    filtered_px_t exp_px;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_px.size() == 0) begin
        report_mismatch($sformatf("unexpected result col %0d row %0d", out_col, out_row));
      end else begin
        exp_px = pending_px.pop_front();
        if (out_col !== exp_px.col)
          report_mismatch($sformatf("out_col %0d exp %0d", out_col, exp_px.col));
        if (out_row !== exp_px.row)
          report_mismatch($sformatf("out_row %0d exp %0d", out_row, exp_px.row));
        if (red_median !== exp_px.red)
          report_mismatch($sformatf("red_median %0d exp %0d", red_median, exp_px.red));
        if (green_median !== exp_px.green)
          report_mismatch($sformatf("green_median %0d exp %0d", green_median, exp_px.green));
        if (blue_median !== exp_px.blue)
          report_mismatch($sformatf("blue_median %0d exp %0d", blue_median, exp_px.blue));
        if (alpha_copy !== exp_px.alpha)
          report_mismatch($sformatf("alpha_copy %0d exp %0d", alpha_copy, exp_px.alpha));
        if (run_last !== exp_px.last)
          report_mismatch($sformatf("run_last %0d exp %0d", run_last, exp_px.last));
      end
    end
  end

  // called at a rising edge; returns at the edge of the transaction
  task automatic send_pixel(input logic [7:0] r8, g8, b8, a8);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    red_in <= r8;
    green_in <= g8;
    blue_in <= b8;
    alpha_in <= a8;
    do @(posedge clk); while (!in_ready);
    predict_pixel(r8, g8, b8, a8);
    pixels_sent++;
  endtask

  task automatic send_random_pixel();
    send_pixel(8'($urandom_range(255)), 8'($urandom_range(255)), 8'($urandom_range(255)),
               8'($urandom_range(255)));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_px.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      mfw_pkg::REG_WIDTH: img_width = value[10:0];
      mfw_pkg::REG_HEIGHT: img_height = value;
      mfw_pkg::REG_RADIUS: win_radius = value[2:0];
      default: ;
    endcase
    if (idx != REG_UNUSED) begin
      next_col = 0;
      next_row = 0;
    end
    @(posedge clk);
  endtask

  task automatic set_frame(input logic [15:0] w, h, r);
    write_reg(mfw_pkg::REG_WIDTH, w);
    write_reg(mfw_pkg::REG_HEIGHT, h);
    write_reg(mfw_pkg::REG_RADIUS, r);
  endtask

  task automatic test_directed();
    // small frame with extreme values, then wrap into the next frame
    set_frame(16'd4, 16'd3, 16'd1);
    for (int i = 0; i < 14; i++)
      send_pixel(i[0] ? 8'hFF : 8'h00, i[1] ? 8'hFF : 8'h00, 8'(i * 37), 8'(255 - i));
    wait_drained();
    // zero width, height and radius act as one
    set_frame(16'd0, 16'd0, 16'd0);
    send_pixel(8'h12, 8'h34, 8'h56, 8'h78);
    send_pixel(8'hFF, 8'h00, 8'hFF, 8'h00);
    wait_drained();
    // saturated width, tallest frame, unused register index
    set_frame(16'h07FF, 16'hFFFF, 16'd1);
    write_reg(REG_UNUSED, 16'hFFFF);
    repeat (4) send_random_pixel();
    wait_drained();
    set_frame(16'd1024, 16'd1, 16'd1);
    repeat (4) send_random_pixel();
    wait_drained();
    set_frame(16'd1, 16'd65535, 16'd1);
    repeat (3) send_random_pixel();
    wait_drained();
  endtask

  task automatic test_max_radius();
    // whole frame finishes on one pixel at the largest radius
    set_frame(16'd5, 16'd5, 16'd7);
    repeat (25) send_random_pixel();
    wait_drained();
    set_frame(16'd2, 16'd2, 16'h7);
    repeat (4) send_random_pixel();
    wait_drained();
  endtask

  task automatic test_random_frames(input int idle_pct, input int stall);
    int w, h, sent;
    send_idle_pct = idle_pct;
    stall_pct = stall;
    w = $urandom_range(1, 4);
    h = $urandom_range(1, 4);
    set_frame(16'(w), 16'(h), 16'($urandom_range(1, 3)));
    sent = 0;
    while (sent < 6) begin
      // mostly whole frames, sometimes a cut-short one
      if ($urandom_range(9) == 0) begin
        repeat ($urandom_range(1, w * h)) begin
          send_random_pixel();
          sent++;
        end
        wait_drained();
        set_frame(16'(w), 16'(h), 16'($urandom_range(1, 3)));
      end else begin
        repeat (w * h) begin
          send_random_pixel();
          sent++;
        end
      end
    end
    wait_drained();
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    stall_pct = 0;
    set_frame(16'd3, 16'd3, 16'd1);
    hold_cycles = 1500;
    repeat (9) send_random_pixel();
    wait_drained();
    repeat (5) send_random_pixel();
    wait_drained();
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed();
    test_max_radius();
    test_random_frames(0, 0);
    test_random_frames(70, 0);
    test_random_frames(0, 70);
    test_random_frames(21, 21);
    test_backpressure();
    repeat (50) @(posedge clk);
    $display("sent %0d pixels, checked %0d filtered pixels", pixels_sent, results_seen);
    $display("covered radius and size extremes, frame wrap, stalls and a long hold");
    if (errors == 0 && pending_px.size() == 0) begin
      $display("median_filter_rgba8_window test passed");
    end else begin
      $display("%0d mismatches, %0d results missing", errors, pending_px.size());
      $display("median_filter_rgba8_window test failed");
    end
    $finish;
  end

  initial begin
    #100ms;
    $display("timeout");
    $display("median_filter_rgba8_window test failed");
    $finish;
  end

endmodule

FILE: median_filter_rgba8_window.f
+incdir+sv
sv/mfw_pkg.sv
sv/mfw_ram.sv
sv/mfw_lane.sv
sv/median_filter_rgba8_window.sv
tb/median_filter_rgba8_window_test.sv
